/* sv/ebalu_pkg.sv */
// Shared constants and types of the elementwise binary ALU.
// Depends on nothing; ebalu_prep, the core and the bench take their names from here.
package ebalu_pkg;

    localparam int MAX_WIDTH_DEF = 64;

    // operation codes
    localparam logic [3:0] OP_ADD  = 4'd0;
    localparam logic [3:0] OP_SUB  = 4'd1;
    localparam logic [3:0] OP_MUL  = 4'd2;
    localparam logic [3:0] OP_DIV  = 4'd3;
    localparam logic [3:0] OP_MAX  = 4'd4;
    localparam logic [3:0] OP_MIN  = 4'd5;
    localparam logic [3:0] OP_AND  = 4'd6;
    localparam logic [3:0] OP_OR   = 4'd7;
    localparam logic [3:0] OP_XOR  = 4'd8;
    localparam logic [3:0] OP_GT   = 4'd9;
    localparam logic [3:0] OP_LT   = 4'd10;
    localparam logic [3:0] OP_GE   = 4'd11;
    localparam logic [3:0] OP_LE   = 4'd12;
    localparam logic [3:0] OP_EQ   = 4'd13;
    localparam logic [3:0] OP_NE   = 4'd14;
    localparam logic [3:0] OP_RSVD = 4'd15;   // undefined code, flagged unsupported

    // error codes
    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_DIV0  = 2'd1;
    localparam logic [1:0] ERR_UNSUP = 2'd2;

    // register indexes
    localparam logic [1:0] REG_OP     = 2'd0;
    localparam logic [1:0] REG_WCODE  = 2'd1;
    localparam logic [1:0] REG_SIGNED = 2'd2;

    localparam logic [2:0] WCODE_RESET = 3'd3;

    typedef struct packed {
        logic [3:0] op;
        logic [2:0] wcode;
        logic       sgn;
    } t_cfg;

    typedef struct packed {
        logic [3:0] op;
        logic       neg_q;
        logic [1:0] err;
    } t_ctl;

endpackage

/* sv/ebalu_if.sv */
// Valid/ready channels of the ALU: operand pairs in, results out.
// Depends on nothing.
interface ebalu_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] lhs_value;
    logic [63:0] rhs_value;
    modport source (output valid, output lhs_value, output rhs_value, input ready);
    modport sink   (input valid, input lhs_value, input rhs_value, output ready);
endinterface

interface ebalu_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_value;
    logic [1:0]  error_code;
    modport source (output valid, output result_value, output error_code, input ready);
    modport sink   (input valid, input result_value, input error_code, output ready);
endinterface

/* sv/ebalu_prep.sv */
// Front stage logic: masking, signed compare, simple ops, divider set-up.
// Depends on ebalu_pkg.
module ebalu_prep #(
    parameter int W = ebalu_pkg::MAX_WIDTH_DEF
) (
    input  ebalu_pkg::t_cfg i_cfg,
    input  logic [63:0]     i_lhs,
    input  logic [63:0]     i_rhs,
    output ebalu_pkg::t_ctl o_ctl,
    output logic [W-1:0]    o_mask,
    output logic [W-1:0]    o_a,
    output logic [W-1:0]    o_b,
    output logic [W-1:0]    o_simple,
    output logic [W-1:0]    o_mag_a,
    output logic [W-1:0]    o_mag_b
);
    logic         w_bool;
    logic [6:0]   w_ew;
    logic [W-1:0] w_sbit, w_a, w_b, w_ax, w_bx;
    logic         w_sgn, w_na, w_nb, w_lt_ab, w_lt_ba, w_anz, w_bnz;

    assign w_bool = i_cfg.wcode[2];
    assign w_ew   = w_bool ? 7'd1 : (7'd8 << i_cfg.wcode[1:0]);

    always_comb begin
        for (int i = 0; i < W; i++) begin
            o_mask[i] = 7'(i) < w_ew;
        end
    end

    assign w_sbit  = o_mask & ~(o_mask >> 1);
    assign w_sgn   = !w_bool && i_cfg.sgn;
    assign w_a     = i_lhs[W-1:0] & o_mask;
    assign w_b     = i_rhs[W-1:0] & o_mask;
    assign w_ax    = w_sgn ? (w_a ^ w_sbit) : w_a;
    assign w_bx    = w_sgn ? (w_b ^ w_sbit) : w_b;
    assign w_lt_ab = w_ax < w_bx;
    assign w_lt_ba = w_bx < w_ax;
    assign w_anz   = w_a != '0;
    assign w_bnz   = w_b != '0;
    assign w_na    = w_sgn && ((w_a & w_sbit) != '0);
    assign w_nb    = w_sgn && ((w_b & w_sbit) != '0);

    assign o_a     = w_a;
    assign o_b     = w_b;
    assign o_mag_a = w_na ? ((~w_a + W'(1)) & o_mask) : w_a;
    assign o_mag_b = w_nb ? ((~w_b + W'(1)) & o_mask) : w_b;

    always_comb begin
        unique case (i_cfg.op)
            ebalu_pkg::OP_ADD: o_simple = (w_a + w_b) & o_mask;
            ebalu_pkg::OP_SUB: o_simple = (w_a - w_b) & o_mask;
            ebalu_pkg::OP_MAX: o_simple = w_lt_ab ? w_b : w_a;
            ebalu_pkg::OP_MIN: o_simple = w_lt_ba ? w_b : w_a;
            ebalu_pkg::OP_AND: o_simple = W'(w_anz && w_bnz);
            ebalu_pkg::OP_OR:  o_simple = W'(w_anz || w_bnz);
            ebalu_pkg::OP_XOR: o_simple = W'(w_anz != w_bnz);
            ebalu_pkg::OP_GT:  o_simple = W'(w_lt_ba);
            ebalu_pkg::OP_LT:  o_simple = W'(w_lt_ab);
            ebalu_pkg::OP_GE:  o_simple = W'(!w_lt_ab);
            ebalu_pkg::OP_LE:  o_simple = W'(!w_lt_ba);
            ebalu_pkg::OP_EQ:  o_simple = W'(w_a == w_b);
            ebalu_pkg::OP_NE:  o_simple = W'(w_a != w_b);
            default:           o_simple = '0;
        endcase
    end

    always_comb begin
        o_ctl.op    = i_cfg.op;
        o_ctl.neg_q = w_na ^ w_nb;
        priority if (i_cfg.op == ebalu_pkg::OP_RSVD) begin
            o_ctl.err = ebalu_pkg::ERR_UNSUP;
        end else if (i_cfg.op <= ebalu_pkg::OP_DIV && w_bool) begin
            o_ctl.err = ebalu_pkg::ERR_UNSUP;
        end else if (i_cfg.op == ebalu_pkg::OP_DIV && !w_bnz) begin
            o_ctl.err = ebalu_pkg::ERR_DIV0;
        end else begin
            o_ctl.err = ebalu_pkg::ERR_OK;
        end
    end
endmodule

/* sv/ebalu_div_stage.sv */
// One restoring division step: one quotient bit per pipeline stage.
// Depends on nothing.
module ebalu_div_stage #(
    parameter int W = 64
) (
    input  logic [W-1:0] i_rem,
    input  logic [W-1:0] i_quo,
    input  logic [W-1:0] i_dvs,
    output logic [W-1:0] o_rem,
    output logic [W-1:0] o_quo
);
    logic [W:0] w_trial, w_diff;
    logic       w_fit;

    assign w_trial = {i_rem, i_quo[W-1]};
    assign w_diff  = w_trial - {1'b0, i_dvs};
    assign w_fit   = w_trial >= {1'b0, i_dvs};
    assign o_rem   = w_fit ? w_diff[W-1:0] : w_trial[W-1:0];
    assign o_quo   = {i_quo[W-2:0], w_fit};
endmodule

/* sv/elementwise_binary_alu_core.sv */
// Top level of the elementwise binary ALU.
// Depends on ebalu_pkg, ebalu_if, ebalu_prep, ebalu_div_stage.
//
// Use:
//   i_in  : operand beats (lhs_value, rhs_value), valid/ready.
//   o_out : result beats (result_value, error_code), valid/ready.
//   i_cfg_*: register writes (0 operation, 1 element width code, 2 signedness);
//            make them only while the pipeline is empty (the block does not enforce it).
// Every item takes the same path: a front stage (masking, compares,
//   add/sub, logic ops, operand magnitudes), MAX_WIDTH divider stages
//   of one quotient bit each, three multiplier stages of one half-width
//   partial product each, and the output register that picks the result.
// Throughput: one beat per cycle while the output is not stalled; set by the
//   divider pipeline, which holds one item per stage.
// Reset clears all valid bits and loads the register reset values.
// Stall: when o_out is valid and not taken, the whole pipeline holds
//   and i_in.ready drops; nothing is lost or repeated. Bubbles move on
//   whenever the output is empty or taken.
module elementwise_binary_alu_core #(
    parameter int MAX_WIDTH = ebalu_pkg::MAX_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [3:0] i_cfg_data,
    ebalu_in_if.sink   i_in,
    ebalu_out_if.source o_out
);
    localparam int W = MAX_WIDTH;
    localparam int H = (W + 1) / 2; // low half of the multiplier split
    localparam int L = W - H;       // high half

    // configuration
    ebalu_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.op    <= ebalu_pkg::OP_ADD;
            r_cfg.wcode <= ebalu_pkg::WCODE_RESET;
            r_cfg.sgn   <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ebalu_pkg::REG_OP:     r_cfg.op    <= i_cfg_data;
                ebalu_pkg::REG_WCODE:  r_cfg.wcode <= i_cfg_data[2:0];
                ebalu_pkg::REG_SIGNED: r_cfg.sgn   <= i_cfg_data[0];
                default: ;             // index beyond the register list
            endcase
        end
    end

    // pipeline advance: everything moves unless the output beat is held
    logic w_en;
    assign w_en       = !o_out.valid || o_out.ready;
    assign i_in.ready = w_en;

    // valid bits: stages 0..W (front + divider), then three tail stages
    logic [W+3:0] r_vld;
    logic         r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_vld     <= {r_vld[W+2:0], i_in.valid};
            r_out_vld <= r_vld[W+3];
        end
    end

    // front stage
    ebalu_pkg::t_ctl w_ctl0;
    logic [W-1:0]    w_mask0, w_a0, w_b0, w_simple0, w_mag_a0, w_mag_b0;

    ebalu_prep #(.W(W)) u_prep (
        .i_cfg    (r_cfg),
        .i_lhs    (i_in.lhs_value),
        .i_rhs    (i_in.rhs_value),
        .o_ctl    (w_ctl0),
        .o_mask   (w_mask0),
        .o_a      (w_a0),
        .o_b      (w_b0),
        .o_simple (w_simple0),
        .o_mag_a  (w_mag_a0),
        .o_mag_b  (w_mag_b0)
    );

    // stage arrays: index 0 front, 1..W divider steps
    ebalu_pkg::t_ctl r_ctl [0:W];
    logic [W-1:0] r_mask [0:W];
    logic [W-1:0] r_a [0:W];
    logic [W-1:0] r_b [0:W];
    logic [W-1:0] r_simple [0:W];
    logic [W-1:0] r_rem [0:W];
    logic [W-1:0] r_quo [0:W];
    logic [W-1:0] r_dvs [0:W];
    logic [W-1:0] w_rem [1:W];
    logic [W-1:0] w_quo [1:W];

    for (genvar s = 1; s <= W; s++) begin : g_div
        ebalu_div_stage #(.W(W)) u_step (
            .i_rem (r_rem[s-1]),
            .i_quo (r_quo[s-1]),
            .i_dvs (r_dvs[s-1]),
            .o_rem (w_rem[s]),
            .o_quo (w_quo[s])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ctl[0]    <= w_ctl0;
            r_mask[0]   <= w_mask0;
            r_a[0]      <= w_a0;
            r_b[0]      <= w_b0;
            r_simple[0] <= w_simple0;
            r_rem[0]    <= '0;
            r_quo[0]    <= w_mag_a0;   // dividend shifts out as quotient shifts in
            r_dvs[0]    <= w_mag_b0;
            for (int s = 1; s <= W; s++) begin
                r_ctl[s]    <= r_ctl[s-1];
                r_mask[s]   <= r_mask[s-1];
                r_a[s]      <= r_a[s-1];
                r_b[s]      <= r_b[s-1];
                r_simple[s] <= r_simple[s-1];
                r_dvs[s]    <= r_dvs[s-1];
                r_rem[s]    <= w_rem[s];
                r_quo[s]    <= w_quo[s];
            end
        end
    end

    // tail: one partial product per stage, low W bits of a*b
    ebalu_pkg::t_ctl r_t_ctl [0:2];
    logic [W-1:0] r_t_mask [0:2];
    logic [W-1:0] r_t_simple [0:2];
    logic [W-1:0] r_t_quo [0:2];
    logic [W-1:0] r_t_a [0:1];
    logic [W-1:0] r_t_b [0:1];
    logic [W-1:0] r_p0 [0:2];
    logic [L-1:0] r_p1 [1:2];
    logic [L-1:0] r_p2;
    logic [W-1:0] w_p0;
    logic [L-1:0] w_p1, w_p2;

    // cross terms only matter below bit W, so their operands keep L bits
    assign w_p0 = W'(r_a[W][H-1:0]) * W'(r_b[W][H-1:0]);
    assign w_p1 = L'(r_t_a[0][H-1:0]) * r_t_b[0][W-1:H];
    assign w_p2 = r_t_a[1][W-1:H] * L'(r_t_b[1][H-1:0]);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t_ctl[0]    <= r_ctl[W];
            r_t_mask[0]   <= r_mask[W];
            r_t_simple[0] <= r_simple[W];
            r_t_quo[0]    <= r_quo[W];
            r_t_a[0]      <= r_a[W];
            r_t_b[0]      <= r_b[W];
            r_p0[0]       <= w_p0;
            for (int t = 1; t <= 2; t++) begin
                r_t_ctl[t]    <= r_t_ctl[t-1];
                r_t_mask[t]   <= r_t_mask[t-1];
                r_t_simple[t] <= r_t_simple[t-1];
                r_t_quo[t]    <= r_t_quo[t-1];
                r_p0[t]       <= r_p0[t-1];
            end
            r_t_a[1] <= r_t_a[0];
            r_t_b[1] <= r_t_b[0];
            r_p1[1]  <= w_p1;
            r_p1[2]  <= r_p1[1];
            r_p2     <= w_p2;
        end
    end

    // output stage: product sum, quotient sign, final pick
    logic [W-1:0]    w_prod, w_q, w_res;
    logic [L-1:0]    w_cross;
    ebalu_pkg::t_ctl w_ctl3;

    assign w_ctl3  = r_t_ctl[2];
    assign w_cross = r_p1[2] + r_p2;
    assign w_prod  = (r_p0[2] + {w_cross, {H{1'b0}}}) & r_t_mask[2];
    assign w_q     = (w_ctl3.neg_q ? (~r_t_quo[2] + W'(1)) : r_t_quo[2]) & r_t_mask[2];

    always_comb begin
        if (w_ctl3.err != ebalu_pkg::ERR_OK) begin
            w_res = '0;
        end else if (w_ctl3.op == ebalu_pkg::OP_MUL) begin
            w_res = w_prod;
        end else if (w_ctl3.op == ebalu_pkg::OP_DIV) begin
            w_res = w_q;
        end else begin
            w_res = r_t_simple[2];
        end
    end

    logic [63:0]     r_out_res;
    ebalu_pkg::t_ctl r_out_ctl;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_res <= 64'(w_res);
            r_out_ctl <= w_ctl3;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.result_value = r_out_res;
    assign o_out.error_code   = r_out_ctl.err;

    // checks
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.error_code != ebalu_pkg::ERR_OK) |-> o_out.result_value == 64'd0)
        else $error("error beat carries a nonzero result");

    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.error_code != 2'd3)
        else $error("undefined error code");

    a_bool_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && r_out_ctl.op >= ebalu_pkg::OP_AND && r_out_ctl.op <= ebalu_pkg::OP_NE)
        |-> o_out.result_value <= 64'd1)
        else $error("logic or compare result not 0/1");
endmodule

/* verif/ebalu_test_if.sv */
`timescale 1ns / 100ps
// Note: the channel interfaces ebalu_in_if and ebalu_out_if come with the RTL (sv/ebalu_if.sv).
// This file only holds a small pair of beat types shared across the bench.
// Depends on nothing.
package ebalu_test_pkg;
    typedef struct packed {
        logic [63:0] lhs;
        logic [63:0] rhs;
    } t_operand_beat;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  err;
    } t_result_beat;
endpackage

/* verif/elementwise_binary_alu_core_test.sv */
`timescale 1ns / 100ps
// Self-checking bench for elementwise_binary_alu_core: random and directed operand beats
// under every operation and every width code, checked against an in-bench ALU model.
// Depends on ebalu_pkg, ebalu_if, ebalu_test_pkg and the core RTL.
module elementwise_binary_alu_core_test;

    localparam int LATENCY    = ebalu_pkg::MAX_WIDTH_DEF + 4;
    localparam int STALL_LIMIT = 5000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [3:0] i_cfg_data;

    ebalu_in_if  in_ch ();
    ebalu_out_if out_ch ();

    elementwise_binary_alu_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // model copy of the registers
    logic [3:0] alu_op;
    logic [2:0] alu_wcode;
    logic       alu_sgn;

    ebalu_test_pkg::t_operand_beat operand_q[$];   // waiting to be driven
    ebalu_test_pkg::t_result_beat  result_q[$];    // predicted, waiting at the output

    int  mismatches;
    int  idle_cycles;
    bit  timed_out;
    bit  gate_open;      // initial block may hold the driver
    int  burst_left;
    int  gap_left;
    int  stall_phase;

    // signed-aware less-than on element-masked operands
    function automatic bit elem_less(logic [63:0] a, logic [63:0] b,
                                     logic [63:0] sbit, bit sgn);
        if (sgn) begin
            a = a ^ sbit;
            b = b ^ sbit;
        end
        return a < b;
    endfunction

    function automatic ebalu_test_pkg::t_result_beat alu_predict(
            ebalu_test_pkg::t_operand_beat beat);
        ebalu_test_pkg::t_result_beat res;
        bit          is_bool;
        int          w;
        logic [63:0] mask, sbit, a, b, r, ma, mb, q;
        bit          sgn, na, nb;
        is_bool = (alu_wcode >= 3'd4);
        w       = is_bool ? 1 : (8 << alu_wcode);
        mask    = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
        sbit    = 64'd1 << (w - 1);
        sgn     = !is_bool && alu_sgn;
        a       = beat.lhs & mask;
        b       = beat.rhs & mask;
        r       = '0;
        res.err = ebalu_pkg::ERR_OK;
        case (alu_op)
            ebalu_pkg::OP_ADD, ebalu_pkg::OP_SUB, ebalu_pkg::OP_MUL, ebalu_pkg::OP_DIV: begin
                if (is_bool) begin
                    res.err = ebalu_pkg::ERR_UNSUP;
                end else if (alu_op == ebalu_pkg::OP_ADD) begin
                    r = a + b;
                end else if (alu_op == ebalu_pkg::OP_SUB) begin
                    r = a - b;
                end else if (alu_op == ebalu_pkg::OP_MUL) begin
                    r = a * b;
                end else if (b == 64'd0) begin
                    res.err = ebalu_pkg::ERR_DIV0;
                end else if (!sgn) begin
                    r = a / b;
                end else begin
                    na = (a & sbit) != 64'd0;
                    nb = (b & sbit) != 64'd0;
                    ma = na ? ((64'd0 - a) & mask) : a;
                    mb = nb ? ((64'd0 - b) & mask) : b;
                    q  = ma / mb;
                    r  = (na != nb) ? (64'd0 - q) : q;
                end
            end
            ebalu_pkg::OP_MAX: r = elem_less(a, b, sbit, sgn) ? b : a;
            ebalu_pkg::OP_MIN: r = elem_less(b, a, sbit, sgn) ? b : a;
            ebalu_pkg::OP_AND: r = 64'(a != 64'd0 && b != 64'd0);
            ebalu_pkg::OP_OR:  r = 64'(a != 64'd0 || b != 64'd0);
            ebalu_pkg::OP_XOR: r = 64'((a != 64'd0) != (b != 64'd0));
            ebalu_pkg::OP_GT:  r = 64'(elem_less(b, a, sbit, sgn));
            ebalu_pkg::OP_LT:  r = 64'(elem_less(a, b, sbit, sgn));
            ebalu_pkg::OP_GE:  r = 64'(!elem_less(a, b, sbit, sgn));
            ebalu_pkg::OP_LE:  r = 64'(!elem_less(b, a, sbit, sgn));
            ebalu_pkg::OP_EQ:  r = 64'(a == b);
            ebalu_pkg::OP_NE:  r = 64'(a != b);
            default: res.err = ebalu_pkg::ERR_UNSUP;
        endcase
        res.value = r & mask;
        return res;
    endfunction

    // Driver: bursts with random gaps; valid held until the beat is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            burst_left  <= 0;
            gap_left    <= 0;
        end else if (in_ch.valid && !in_ch.ready) begin
            // beat pending, hold
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                result_q.push_back(alu_predict(operand_q.pop_front()));
            end
            if (gap_left > 0) begin
                gap_left    <= gap_left - 1;
                in_ch.valid <= 1'b0;
            end else if (gate_open && operand_q.size() > 0) begin
                in_ch.valid     <= 1'b1;
                in_ch.lhs_value <= operand_q[0].lhs;
                in_ch.rhs_value <= operand_q[0].rhs;
                if (burst_left > 0) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(40, 1);
                    // some bursts run back to back
                    gap_left   <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
                end
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern: phases of free flow, light and heavy stalling.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_phase  <= 0;
        end else begin
            stall_phase <= stall_phase + 1;
            case ((stall_phase / 300) % 3)
                0:       out_ch.ready <= 1'b1;
                1:       out_ch.ready <= ($urandom_range(3, 0) != 0);
                default: out_ch.ready <= ($urandom_range(3, 0) == 0);
            endcase
        end
    end

    // Monitor: compare each result beat against the oldest prediction.
    always @(posedge i_clk) begin
        ebalu_test_pkg::t_result_beat want;
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (out_ch.valid && out_ch.ready) begin
                if (result_q.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected result beat value=%h err=%0d",
                                 out_ch.result_value, out_ch.error_code);
                end else begin
                    want = result_q.pop_front();
                    if (want.value !== out_ch.result_value || want.err !== out_ch.error_code) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("result mismatch: want %h/%0d got %h/%0d",
                                     want.value, want.err,
                                     out_ch.result_value, out_ch.error_code);
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no beat moving either way.
    always @(posedge i_clk) begin
        if (idle_cycles >= STALL_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [3:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            ebalu_pkg::REG_OP:     alu_op    = data;
            ebalu_pkg::REG_WCODE:  alu_wcode = data[2:0];
            ebalu_pkg::REG_SIGNED: alu_sgn   = data[0];
            default: ;
        endcase
    endtask

    // Let the pipeline empty: queue consumed, all results in, tail latency.
    task automatic drain();
        while (operand_q.size() > 0 || in_ch.valid || result_q.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Operands that favour corners: zero, one, all ones, sign bit, largest positive, small, random.
    function automatic logic [63:0] pick_operand();
        logic [63:0] sbit;
        int          w;
        w    = (alu_wcode >= 3'd4) ? 1 : (8 << alu_wcode);
        sbit = 64'd1 << (w - 1);
        case ($urandom_range(9, 0))
            0: return 64'd0;
            1: return 64'd1;
            2: return '1;
            3: return sbit | (rand64() & ~((sbit << 1) - 64'd1));
            4: return sbit - 64'd1;
            5: return rand64() & 64'h7;
            default: return rand64();
        endcase
    endfunction

    task automatic push_pair(logic [63:0] lhs, logic [63:0] rhs);
        ebalu_test_pkg::t_operand_beat beat;
        beat.lhs = lhs;
        beat.rhs = rhs;
        operand_q.push_back(beat);
    endtask

    initial begin
        logic [3:0] op_pick;
        logic [2:0] wc_pick;
        int         n;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = ebalu_pkg::REG_OP;
        i_cfg_data      = '0;
        in_ch.valid     = 1'b0;
        in_ch.lhs_value = '0;
        in_ch.rhs_value = '0;
        out_ch.ready    = 1'b0;
        mismatches      = 0;
        idle_cycles     = 0;
        timed_out       = 1'b0;
        gate_open       = 1'b1;
        alu_op          = ebalu_pkg::OP_ADD;
        alu_wcode       = ebalu_pkg::WCODE_RESET;
        alu_sgn         = 1'b1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset setting (64-bit signed add) at the extremes.
        push_pair('1, 64'd1);
        push_pair(64'h8000_0000_0000_0000, '1);
        drain();

        // Division specials at 64-bit signed: min / -1, divide by zero, negative dividend.
        write_reg(ebalu_pkg::REG_OP, ebalu_pkg::OP_DIV);
        push_pair(64'h8000_0000_0000_0000, '1);
        push_pair(64'd7, 64'd0);
        push_pair(-64'sd7, 64'd2);
        drain();

        // Bool: arithmetic unsupported, max/min as or/and; wide codes also bool.
        write_reg(ebalu_pkg::REG_WCODE, 4'd4);
        push_pair(64'd1, 64'd1);
        drain();
        write_reg(ebalu_pkg::REG_OP, ebalu_pkg::OP_MAX);
        push_pair(64'd2, 64'd1);
        push_pair(64'd1, 64'd0);
        drain();
        write_reg(ebalu_pkg::REG_WCODE, 4'd7);
        write_reg(ebalu_pkg::REG_OP, ebalu_pkg::OP_MIN);
        push_pair(64'd3, 64'd1);
        drain();

        // Undefined operation code.
        write_reg(ebalu_pkg::REG_OP, ebalu_pkg::OP_RSVD);
        push_pair(64'd5, 64'd6);
        drain();

        // Every operation once at 8-bit unsigned, sign-bit lhs and rhs of one.
        write_reg(ebalu_pkg::REG_WCODE, 4'd0);
        write_reg(ebalu_pkg::REG_SIGNED, 4'd0);
        for (int op = 0; op < 15; op++) begin
            write_reg(ebalu_pkg::REG_OP, op[3:0]);
            push_pair(64'hFFFF_FF80, 64'h0000_0101);
            drain();
        end

        // Random phases across settings; a pause for an empty pipeline each time.
        for (int ph = 0; ph < 24; ph++) begin
            op_pick = (ph % 8 == 7) ? ebalu_pkg::OP_RSVD : 4'($urandom_range(14, 0));
            wc_pick = (ph < 8) ? ph[2:0] : 3'($urandom_range(7, 0));
            write_reg(ebalu_pkg::REG_OP, op_pick);
            write_reg(ebalu_pkg::REG_WCODE, {1'b0, wc_pick});
            write_reg(ebalu_pkg::REG_SIGNED, 4'($urandom_range(1, 0)));
            n = $urandom_range(80, 50);
            for (int k = 0; k < n; k++)
                push_pair(pick_operand(), pick_operand());
            drain();
        end

        // Reset values restored at the end.
        write_reg(ebalu_pkg::REG_OP, ebalu_pkg::OP_ADD);
        write_reg(ebalu_pkg::REG_WCODE, {1'b0, ebalu_pkg::WCODE_RESET});
        write_reg(ebalu_pkg::REG_SIGNED, 4'd1);
        push_pair(rand64(), rand64());
        drain();

        if (mismatches == 0 && result_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

/* sim.f */
sv/ebalu_pkg.sv
sv/ebalu_if.sv
sv/ebalu_prep.sv
sv/ebalu_div_stage.sv
sv/elementwise_binary_alu_core.sv
verif/ebalu_test_if.sv
verif/elementwise_binary_alu_core_test.sv
